// File: hw/rtl/accumulator_machine_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// accumulator machine execute unit assertion macros
// immediate and next-cycle implication checks, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define AMX_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define AMX_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define AMX_ASSERT_NOW(lbl, pre, post, msg)
`define AMX_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hw/rtl/amx_pkg.sv
// ----------------------------------------------------------------------------
// amx_pkg
// shared types, opcodes and status codes of the accumulator machine execute unit
// ----------------------------------------------------------------------------
package amx_pkg;

    localparam int DATA_WORDS_DEF = 128;
    localparam int MAX_JUMP_DEF   = 127;

    // instruction opcodes as they arrive
    localparam logic [3:0] OP_DEC = 4'd0;
    localparam logic [3:0] OP_LDI = 4'd1;
    localparam logic [3:0] OP_LDA = 4'd2;
    localparam logic [3:0] OP_STR = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_SUB = 4'd5;
    localparam logic [3:0] OP_XCH = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JZS = 4'd8;
    localparam logic [3:0] OP_HLT = 4'd9;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD_JUMP = 2'd2;
    localparam logic [1:0] ST_HALTED   = 2'd3;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_LDI,
        CLS_LDA,
        CLS_STR,
        CLS_ADD,
        CLS_SUB,
        CLS_XCH,
        CLS_JMP,
        CLS_JZS,
        CLS_HLT
    } t_cls;

    // classified instruction, front to back
    typedef struct packed {
        t_cls               cls;
        logic signed [15:0] imm;
        logic [6:0]         addr;      // already reduced modulo the store depth
        logic               jump_bad;  // target above the jump limit
        logic [6:0]         pc;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] acc;
        logic signed [15:0] dr;
        logic               zero;
        logic               pc_load;
        logic [6:0]         pc_value;
        logic               halted;
    } t_res;

endpackage

// File: hw/rtl/amx_queue.sv
// ----------------------------------------------------------------------------
// amx_queue
// small register queue used between front and back and on the result side
// ----------------------------------------------------------------------------
module amx_queue #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/amx_front.sv
// ----------------------------------------------------------------------------
// amx_front
// classifies an incoming instruction: opcode class, store index, jump check
// ----------------------------------------------------------------------------
module amx_front #(
    parameter int DATA_WORDS = amx_pkg::DATA_WORDS_DEF,
    parameter int MAX_JUMP   = amx_pkg::MAX_JUMP_DEF
) (
    input  logic [3:0]         i_op,
    input  logic signed [15:0] i_immediate,
    input  logic [6:0]         i_data_address,
    input  logic [7:0]         i_jump_target,
    output amx_pkg::t_cmd      o_cmd
);

    amx_pkg::t_cls w_cls;
    logic [6:0]    w_rem;

    always_comb begin
        unique case (i_op)
            amx_pkg::OP_LDI: w_cls = amx_pkg::CLS_LDI;
            amx_pkg::OP_LDA: w_cls = amx_pkg::CLS_LDA;
            amx_pkg::OP_STR: w_cls = amx_pkg::CLS_STR;
            amx_pkg::OP_ADD: w_cls = amx_pkg::CLS_ADD;
            amx_pkg::OP_SUB: w_cls = amx_pkg::CLS_SUB;
            amx_pkg::OP_XCH: w_cls = amx_pkg::CLS_XCH;
            amx_pkg::OP_JMP: w_cls = amx_pkg::CLS_JMP;
            amx_pkg::OP_JZS: w_cls = amx_pkg::CLS_JZS;
            amx_pkg::OP_HLT: w_cls = amx_pkg::CLS_HLT;
            default:         w_cls = amx_pkg::CLS_NOP;  // dec and unused codes
        endcase
    end

    // address modulo store depth by restoring subtraction of shifted depths
    always_comb begin
        w_rem = i_data_address;
        for (int k = 6; k >= 0; k--) begin
            if ((DATA_WORDS << k) <= 127 && int'(w_rem) >= (DATA_WORDS << k)) begin
                w_rem = w_rem - 7'(DATA_WORDS << k);
            end
        end
    end

    always_comb begin
        o_cmd.cls      = w_cls;
        o_cmd.imm      = i_immediate;
        o_cmd.addr     = w_rem;
        o_cmd.jump_bad = (int'(i_jump_target) > MAX_JUMP);
        o_cmd.pc       = i_jump_target[6:0];
    end

endmodule

// File: hw/rtl/amx_back.sv
// ----------------------------------------------------------------------------
// amx_back
// store read stage, then execute against accumulator, data register and flags
// ----------------------------------------------------------------------------
`include "accumulator_machine_execute_unit_macros.svh"

module amx_back #(
    parameter int DATA_WORDS = amx_pkg::DATA_WORDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  amx_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output amx_pkg::t_res o_res
);

    localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    // data store, valid bit per word stands in for the reset clear
    logic [15:0]           r_mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] r_mem_vld;

    // read stage
    logic                  r_a_valid;
    amx_pkg::t_cmd         r_a_cmd;
    logic [15:0]           r_a_rd;

    // architectural state
    logic [15:0]           r_acc;
    logic [15:0]           r_dr;
    logic                  r_zero;
    logic                  r_halt;

    logic [15:0]           n_acc;
    logic [15:0]           n_dr;
    logic                  n_zero;
    logic                  n_halt;

    logic                  w_fire;
    logic                  w_load;
    logic [AW-1:0]         w_rd_idx;
    logic [AW-1:0]         w_wr_idx;
    logic                  w_store;
    logic                  w_wr_en;
    logic                  w_sub;
    logic [16:0]           w_a17;
    logic [16:0]           w_d17;
    logic [16:0]           w_sum17;
    logic                  w_ovf;
    logic [1:0]            w_status;
    logic                  w_pc_load;
    logic [6:0]            w_pc_value;

    assign w_fire    = r_a_valid && !i_res_full;
    assign w_load    = i_cmd_valid && (!r_a_valid || w_fire);
    assign o_cmd_pop = w_load;
    assign w_rd_idx  = AW'(i_cmd.addr);
    assign w_wr_idx  = AW'(r_a_cmd.addr);
    assign w_wr_en   = w_fire && w_store;

    // one adder for add and sub, overflow from the two top sum bits
    assign w_sub   = (r_a_cmd.cls == amx_pkg::CLS_SUB);
    assign w_a17   = {r_acc[15], r_acc};
    assign w_d17   = {r_dr[15], r_dr};
    assign w_sum17 = w_a17 + (w_sub ? ~w_d17 : w_d17) + 17'(w_sub);
    assign w_ovf   = w_sum17[16] ^ w_sum17[15];

    always_comb begin
        n_acc      = r_acc;
        n_dr       = r_dr;
        n_zero     = r_zero;
        n_halt     = r_halt;
        w_status   = amx_pkg::ST_OK;
        w_pc_load  = 1'b0;
        w_pc_value = '0;
        w_store    = 1'b0;
        if (r_halt) begin
            w_status = amx_pkg::ST_HALTED;
        end else begin
            unique case (r_a_cmd.cls)
                amx_pkg::CLS_LDI: n_acc = r_a_cmd.imm;
                amx_pkg::CLS_LDA: n_acc = r_a_rd;
                amx_pkg::CLS_STR: w_store = 1'b1;
                amx_pkg::CLS_ADD, amx_pkg::CLS_SUB: begin
                    if (w_ovf) begin
                        w_status = amx_pkg::ST_OVERFLOW;
                    end else begin
                        n_acc  = w_sum17[15:0];
                        n_zero = (w_sum17[15:0] == '0);
                    end
                end
                amx_pkg::CLS_XCH: begin
                    n_acc = r_dr;
                    n_dr  = r_acc;
                end
                amx_pkg::CLS_JMP, amx_pkg::CLS_JZS: begin
                    if (r_a_cmd.cls == amx_pkg::CLS_JMP || r_zero) begin
                        if (r_a_cmd.jump_bad) begin
                            w_status = amx_pkg::ST_BAD_JUMP;
                        end else begin
                            w_pc_load  = 1'b1;
                            w_pc_value = r_a_cmd.pc;
                        end
                    end
                end
                amx_pkg::CLS_HLT: n_halt = 1'b1;
                default: ;  // no operation
            endcase
        end
    end

    assign o_res_push      = w_fire;
    assign o_res.status    = w_status;
    assign o_res.acc       = n_acc;
    assign o_res.dr        = n_dr;
    assign o_res.zero      = n_zero;
    assign o_res.pc_load   = w_pc_load;
    assign o_res.pc_value  = w_pc_value;
    assign o_res.halted    = n_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_acc     <= '0;
            r_dr      <= '0;
            r_zero    <= 1'b0;
            r_halt    <= 1'b0;
            r_mem_vld <= '0;
        end else begin
            if (w_load) begin
                r_a_valid <= 1'b1;
            end else if (w_fire) begin
                r_a_valid <= 1'b0;
            end
            if (w_fire) begin
                r_acc  <= n_acc;
                r_dr   <= n_dr;
                r_zero <= n_zero;
                r_halt <= n_halt;
            end
            if (w_wr_en) begin
                r_mem_vld[w_wr_idx] <= 1'b1;
            end
        end
    end

    // store write and registered read, a store in execute forwards to the read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= r_acc;
        end
        if (w_load) begin
            r_a_cmd <= i_cmd;
            if (w_wr_en && w_wr_idx == w_rd_idx) begin
                r_a_rd <= r_acc;
            end else if (r_mem_vld[w_rd_idx]) begin
                r_a_rd <= r_mem[w_rd_idx];
            end else begin
                r_a_rd <= '0;
            end
        end
    end

    `AMX_ASSERT_NEXT(a_halt_sticky, r_halt, r_halt, "halt flag cleared outside reset")
    `AMX_ASSERT_NOW(a_halt_ignores, w_fire && r_halt, o_res.status == amx_pkg::ST_HALTED && !w_wr_en, "item executed while halted")
    `AMX_ASSERT_NEXT(a_ovf_keeps_acc, w_fire && w_status == amx_pkg::ST_OVERFLOW, $stable(r_acc), "accumulator changed on overflow")

endmodule

// File: hw/rtl/accumulator_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// accumulator_machine_execute_unit
// execute stage of a small accumulator machine, one decoded instruction per item
// ----------------------------------------------------------------------------
// One instruction item in, one result item out. The unit sustains one item per
// clock when the result side pops every cycle; the first result of an idle unit
// passes through the command queue, the store read stage and execute into the
// result queue. The store read stage is set by the registered read of the data
// store: the read is issued ahead of execution and a store executing in the
// same cycle is forwarded into it. The store needs no clearing pass after
// reset, since a valid bit per word makes an unwritten word read as zero. full
// rises only when the result queue backs up into the command queue.
// ----------------------------------------------------------------------------
module accumulator_machine_execute_unit #(
    parameter int DATA_WORDS = amx_pkg::DATA_WORDS_DEF,
    parameter int MAX_JUMP   = amx_pkg::MAX_JUMP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // instruction side
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_op,
    input  logic signed [15:0] i_immediate,
    input  logic [6:0]         i_data_address,
    input  logic [7:0]         i_jump_target,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_accumulator_out,
    output logic signed [15:0] o_data_register_out,
    output logic               o_zero_flag,
    output logic               o_pc_load,
    output logic [6:0]         o_pc_value,
    output logic               o_halted_out
);

    amx_pkg::t_cmd w_front_cmd;   // classified item from the front
    amx_pkg::t_cmd w_queue_cmd;   // oldest waiting item for the back
    logic          w_cmd_empty;
    logic          w_cmd_pop;
    logic          w_res_full;
    logic          w_res_push;
    amx_pkg::t_res w_back_res;
    amx_pkg::t_res w_out_res;

    // front: decode opcode, reduce the store address, check the jump target
    amx_front #(
        .DATA_WORDS (DATA_WORDS),
        .MAX_JUMP   (MAX_JUMP)
    ) u_front (
        .i_op           (i_op),
        .i_immediate    (i_immediate),
        .i_data_address (i_data_address),
        .i_jump_target  (i_jump_target),
        .o_cmd          (w_front_cmd)
    );

    // command queue decouples acceptance from execution
    amx_queue #(
        .t_item (amx_pkg::t_cmd),
        .DEPTH  (2)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_queue_cmd),
        .o_empty (w_cmd_empty)
    );

    // back: store read stage and execute, holds all machine state
    amx_back #(
        .DATA_WORDS (DATA_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_queue_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_back_res)
    );

    // result queue parts execution from the consumer
    amx_queue #(
        .t_item (amx_pkg::t_res),
        .DEPTH  (2)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_back_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_out_res),
        .o_empty (empty)
    );

    assign o_status            = w_out_res.status;
    assign o_accumulator_out   = w_out_res.acc;
    assign o_data_register_out = w_out_res.dr;
    assign o_zero_flag         = w_out_res.zero;
    assign o_pc_load           = w_out_res.pc_load;
    assign o_pc_value          = w_out_res.pc_value;
    assign o_halted_out        = w_out_res.halted;

endmodule
